### design/char_lcd_text_writer_macros.svh
// assertion macros shared by the lcd text writer rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef CHAR_LCD_TEXT_WRITER_MACROS_SVH
`define CHAR_LCD_TEXT_WRITER_MACROS_SVH

// same-cycle implication, gated by the active-low reset
`define CLW_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("clw assertion failed");

// next-cycle implication, gated by the active-low reset
`define CLW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("clw assertion failed");

`endif

### design/clw_pkg.sv
// types, codes and helper functions for the lcd text writer
// no dependencies; used by char_lcd_text_writer
`timescale 1ns / 1ps

package clw_pkg;

    typedef enum logic [1:0] {
        ACT_PUT  = 2'd0,
        ACT_SET  = 2'd1,
        ACT_CMD  = 2'd2,
        ACT_DATA = 2'd3
    } t_action;

    localparam logic CFG_COLUMNS = 1'b0;
    localparam logic CFG_ROWS    = 1'b1;

    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CMD_DDRAM = 8'h80;
    localparam logic [2:0] MAX_ROWS = 3'd4;

    localparam logic [6:0] ROW_BASE_0 = 7'h00;
    localparam logic [6:0] ROW_BASE_1 = 7'h40;
    localparam logic [6:0] ROW_BASE_2 = 7'h14;
    localparam logic [6:0] ROW_BASE_3 = 7'h54;

    typedef struct packed {
        t_action     action;
        logic [7:0]  byte_value;
        logic [5:0]  target_col;
        logic [1:0]  target_row;
    } t_in_word;

    typedef struct packed {
        logic [3:0]  nibble;
        logic        reg_select;
        logic        last;
    } t_out_word;

    // row at or past the usable row count folds back to row 0
    function automatic logic [1:0] fix_row(logic [2:0] row, logic [2:0] rows);
        logic [2:0] lim;
        lim = (rows > MAX_ROWS) ? MAX_ROWS : rows;
        if (row >= lim || row >= MAX_ROWS) begin
            return 2'd0;
        end
        return row[1:0];
    endfunction

    // ddram start address of each display row
    function automatic logic [6:0] row_base(logic [1:0] row);
        logic [6:0] base;
        case (row)
            2'd0:    base = ROW_BASE_0;
            2'd1:    base = ROW_BASE_1;
            2'd2:    base = ROW_BASE_2;
            default: base = ROW_BASE_3;
        endcase
        return base;
    endfunction

    function automatic logic [7:0] ddram_cmd(logic [5:0] col, logic [1:0] row);
        logic [6:0] addr;
        addr = 7'({1'b0, col} + row_base(row));
        return CMD_DDRAM | {1'b0, addr};
    endfunction

endpackage

### design/char_lcd_text_writer.sv
// lcd text writer: turns text and commands into a 4-bit nibble stream
// depends on clw_pkg and char_lcd_text_writer_macros.svh
`timescale 1ns / 1ps
`include "char_lcd_text_writer_macros.svh"

// Usage
//   input channel (i_in_valid / o_in_ready / i_in): one word per item, either
//   a character to put, a cursor position, or a raw command or data byte.
//   output channel (o_out_valid / i_out_ready / o_out): one nibble per word,
//   high nibble first, with reg_select and a last flag on the item's final one.
//   config port (i_cfg_we / i_cfg_idx / i_cfg_data): index 0 columns,
//   index 1 rows; write only while the block is idle.
// Timing
//   the cursor and both bytes of an item are worked out in the accepting
//   cycle and held in the nibble register; the first nibble shows the next
//   cycle. an item gives 2 nibbles, or 4 when a character wraps first, and the
//   single output port moves one nibble a cycle while the receiver is ready.
//   a new item is not taken before its predecessor's last nibble is, and is
//   taken in the cycle that last nibble is taken.
// Reset and stall
//   reset clears the cursor to row 0 column 0, sets 16 columns and 2 rows and
//   drops any pending nibbles. while the receiver stalls the current nibble
//   holds and input is refused until the last nibble goes.
module char_lcd_text_writer (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  clw_pkg::t_in_word i_in,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output clw_pkg::t_out_word o_out,
    input  logic              i_cfg_we,
    input  logic              i_cfg_idx,
    input  logic [5:0]        i_cfg_data
);

    logic [5:0] r_columns;
    logic [2:0] r_rows;
    logic [5:0] r_col;
    logic [5:0] n_col;
    logic [1:0] r_row;
    logic [1:0] n_row;

    logic       r_busy;
    logic [1:0] r_idx;
    logic [7:0] r_byte0;
    logic [7:0] n_byte0;
    logic [7:0] r_byte1;
    logic [7:0] n_byte1;
    logic       r_rs0;
    logic       n_rs0;
    logic       r_rs1;
    logic       n_rs1;
    logic       r_two;
    logic       n_two;

    logic       in_acc;
    logic       out_acc;
    logic       cur_last;
    logic       wrap;
    logic [1:0] row_wrap;
    logic [5:0] col_a;
    logic [1:0] row_a;
    logic [7:0] cur_byte;
    logic [7:0] sec_byte;
    logic       sec_rs;
    logic [1:0] row_nl;
    logic [1:0] row_cr;

    assign cur_last    = (r_idx == (r_two ? 2'd3 : 2'd1));
    assign o_out_valid = r_busy;
    assign out_acc     = r_busy && i_out_ready;
    assign o_in_ready  = !r_busy || (i_out_ready && cur_last);
    assign in_acc      = i_in_valid && o_in_ready;

    assign cur_byte         = r_idx[1] ? r_byte1 : r_byte0;
    assign o_out.nibble     = r_idx[0] ? cur_byte[3:0] : cur_byte[7:4];
    assign o_out.reg_select = r_idx[1] ? r_rs1 : r_rs0;
    assign o_out.last       = cur_last;

    // cursor step and the one or two bytes an item sends
    always_comb begin
        wrap     = (r_col >= r_columns);
        row_wrap = clw_pkg::fix_row(3'({1'b0, r_row} + 3'd1), r_rows);
        col_a    = wrap ? 6'd0 : r_col;
        row_a    = wrap ? row_wrap : r_row;
        row_nl   = clw_pkg::fix_row(3'({1'b0, row_a} + 3'd1), r_rows);
        row_cr   = clw_pkg::fix_row({1'b0, row_a}, r_rows);

        n_col    = r_col;
        n_row    = r_row;
        n_byte0  = i_in.byte_value;
        n_rs0    = 1'b0;
        n_byte1  = i_in.byte_value;
        n_rs1    = 1'b1;
        n_two    = 1'b0;
        sec_byte = i_in.byte_value;
        sec_rs   = 1'b1;

        case (i_in.action)
            clw_pkg::ACT_PUT: begin
                if (i_in.byte_value == clw_pkg::CH_NL) begin
                    sec_byte = clw_pkg::ddram_cmd(col_a, row_nl);
                    sec_rs   = 1'b0;
                    n_col    = col_a;
                    n_row    = row_nl;
                end else if (i_in.byte_value == clw_pkg::CH_CR) begin
                    sec_byte = clw_pkg::ddram_cmd(6'd0, row_cr);
                    sec_rs   = 1'b0;
                    n_col    = 6'd0;
                    n_row    = row_cr;
                end else begin
                    n_col = col_a + 6'd1;
                    n_row = row_a;
                end
                if (wrap) begin
                    n_byte0 = clw_pkg::ddram_cmd(6'd0, row_wrap);
                    n_rs0   = 1'b0;
                    n_byte1 = sec_byte;
                    n_rs1   = sec_rs;
                    n_two   = 1'b1;
                end else begin
                    n_byte0 = sec_byte;
                    n_rs0   = sec_rs;
                end
            end
            clw_pkg::ACT_SET: begin
                n_row   = clw_pkg::fix_row({1'b0, i_in.target_row}, r_rows);
                n_col   = i_in.target_col;
                n_byte0 = clw_pkg::ddram_cmd(i_in.target_col, n_row);
            end
            clw_pkg::ACT_CMD: begin
                n_rs0 = 1'b0;
            end
            clw_pkg::ACT_DATA: begin
                n_rs0 = 1'b1;
            end
            default: begin
                n_rs0 = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= 6'd16;
            r_rows    <= 3'd2;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                clw_pkg::CFG_COLUMNS: r_columns <= i_cfg_data;
                clw_pkg::CFG_ROWS:    r_rows    <= i_cfg_data[2:0];
                default:              r_rows    <= r_rows;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= 6'd0;
            r_row  <= 2'd0;
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (in_acc) begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (out_acc) begin
            if (cur_last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    // word payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_byte0 <= n_byte0;
            r_byte1 <= n_byte1;
            r_rs0   <= n_rs0;
            r_rs1   <= n_rs1;
            r_two   <= n_two;
        end
    end

    `CLW_ASSERT_NOW(a_take_only_on_last, i_clk, i_rst_n,
        in_acc && r_busy, out_acc && cur_last)
    `CLW_ASSERT_NEXT(a_item_not_cut, i_clk, i_rst_n,
        out_acc && !cur_last, o_out_valid)
    `CLW_ASSERT_NEXT(a_raw_keeps_cursor, i_clk, i_rst_n,
        in_acc && (i_in.action == clw_pkg::ACT_CMD || i_in.action == clw_pkg::ACT_DATA),
        $stable(r_col) && $stable(r_row))
    `CLW_ASSERT_NOW(a_last_on_low_nibble, i_clk, i_rst_n,
        o_out_valid && o_out.last, r_idx[0])

endmodule
